### sv/smix_pkg.sv
// ----------------------------------------------------------------------------
// smix_pkg: shared types, constants and helpers of the stereo mixer
// Widths, register indexes, the reciprocal for the divide by one hundred and
// the word layout that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package smix_pkg;

  localparam int SampleW    = 16;
  localparam int GainW      = 8;
  localparam int MagW       = 23;  // |sample| * gain never exceeds 8,355,840
  localparam int QuotW      = 17;  // magnitude / 100 never exceeds 83,558
  localparam int MixW       = 19;  // sum of two signed quotients
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 8;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  // floor(m / 100) == (m * RecipK) >> RecipShift for every m below 2^23.
  localparam int RecipKW    = 24;
  localparam int RecipShift = 30;
  localparam logic [RecipKW-1:0] RecipK = 24'd10737419;

  localparam logic [CfgIdxW-1:0] CFG_PSG_GAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FM_GAIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOWPASS  = 2'd2;

  localparam logic [GainW-1:0] GainReset = 8'd100;

  // A scaled source held as sign and magnitude so that the divide truncates
  // towards zero.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } scaled_t;

  typedef struct packed {
    scaled_t psg;
    scaled_t fm_left;
    scaled_t fm_right;
  } front_word_t;

  function automatic scaled_t scale_raw(logic [SampleW-1:0] s, logic [GainW-1:0] g);
    logic [SampleW:0]         a;
    logic [SampleW+GainW:0]   p;
    scaled_t                  r;
    a = s[SampleW-1] ? ((SampleW+1)'(0) - {1'b1, s}) : {1'b0, s};
    p = {{GainW{1'b0}}, a} * {{(SampleW+1){1'b0}}, g};
    r.neg = s[SampleW-1];
    r.mag = p[MagW-1:0];
    return r;
  endfunction

endpackage

### sv/smix_if.sv
// ----------------------------------------------------------------------------
// smix_if: stream channels of the stereo mixer
// Input channel carries one mono and one stereo sample; output channel
// carries the mixed stereo pair. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface smix_in_if import smix_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] psg_sample;
  logic [SampleW-1:0] fm_left_sample;
  logic [SampleW-1:0] fm_right_sample;

  modport source (output valid, output psg_sample, output fm_left_sample,
                  output fm_right_sample, input ready);
  modport sink   (input valid, input psg_sample, input fm_left_sample,
                  input fm_right_sample, output ready);
endinterface

interface smix_out_if import smix_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] left_out;
  logic [SampleW-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### sv/smix_front.sv
// ----------------------------------------------------------------------------
// smix_front: input stage of the stereo mixer
// Takes each input word, applies the two gains as sign and magnitude and
// holds the result until the queue has room.
// ----------------------------------------------------------------------------
module smix_front import smix_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [GainW-1:0] psg_gain,
  input  logic [GainW-1:0] fm_gain,
  smix_in_if.sink          in_ch,
  input  logic             queue_full,
  output logic             push,
  output front_word_t      push_word
);

  logic        word_valid;
  front_word_t word;

  assign in_ch.ready = !word_valid || !queue_full;
  assign push        = word_valid && !queue_full;
  assign push_word   = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ch.ready) begin
      word_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      word.psg      <= scale_raw(in_ch.psg_sample, psg_gain);
      word.fm_left  <= scale_raw(in_ch.fm_left_sample, fm_gain);
      word.fm_right <= scale_raw(in_ch.fm_right_sample, fm_gain);
    end
  end

endmodule

### sv/smix_queue.sv
// ----------------------------------------------------------------------------
// smix_queue: short queue between the front and back parts
// A small circular buffer of scaled words with a fill count.
// ----------------------------------------------------------------------------
module smix_queue import smix_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_word_t push_word,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output front_word_t head_word
);

  front_word_t          entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign full       = (count == (QueuePtrW+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_word  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue fill count beyond depth");
`endif

endmodule

### sv/smix_back.sv
// ----------------------------------------------------------------------------
// smix_back: arithmetic pipeline of the stereo mixer
// Divides the scaled sources by one hundred, mixes, applies the optional
// averaging low-pass and saturates into the output register.
// ----------------------------------------------------------------------------
module smix_back import smix_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        lowpass_enable,
  input  logic        head_valid,
  input  front_word_t head_word,
  output logic        pop,
  smix_out_if.source  out_ch
);

  logic             adv;
  logic             s1_valid;
  logic             s1_neg_psg, s1_neg_l, s1_neg_r;
  logic [QuotW-1:0] s1_q_psg, s1_q_l, s1_q_r;
  logic             s2_valid;
  logic [MixW-1:0]  s2_mix_l, s2_mix_r;
  logic             out_valid;
  logic [SampleW-1:0] out_l, out_r;
  logic [MixW-1:0]  prev_left, prev_right;
  logic [MixW:0]    sum_l, sum_r;
  logic [MixW-1:0]  avg_l, avg_r;
  logic [MixW-1:0]  res_l, res_r;

  function automatic logic [QuotW-1:0] div100(logic [MagW-1:0] m);
    logic [MagW+RecipKW-1:0] p;
    p = {{RecipKW{1'b0}}, m} * {{MagW{1'b0}}, RecipK};
    return p[RecipShift+QuotW-1:RecipShift];
  endfunction

  function automatic logic [MixW-1:0] apply_sign(logic neg, logic [QuotW-1:0] q);
    logic [MixW-1:0] e;
    e = {{(MixW-QuotW){1'b0}}, q};
    return neg ? (MixW'(0) - e) : e;
  endfunction

  function automatic logic [SampleW-1:0] clip16(logic [MixW-1:0] v);
    logic [SampleW-1:0] r;
    if (!v[MixW-1] && v[MixW-2:SampleW-1] != '0) begin
      r = {1'b0, {(SampleW-1){1'b1}}};
    end else if (v[MixW-1] && v[MixW-2:SampleW-1] != '1) begin
      r = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  assign adv          = !out_valid || out_ch.ready;
  assign pop          = adv && head_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.left_out  = out_l;
  assign out_ch.right_out = out_r;

  // Average with the previous value: floor((prev + mix) / 2).
  assign sum_l = {prev_left[MixW-1], prev_left} + {s2_mix_l[MixW-1], s2_mix_l};
  assign sum_r = {prev_right[MixW-1], prev_right} + {s2_mix_r[MixW-1], s2_mix_r};
  assign avg_l = sum_l[MixW:1];
  assign avg_r = sum_r[MixW:1];
  assign res_l = lowpass_enable ? avg_l : s2_mix_l;
  assign res_r = lowpass_enable ? avg_r : s2_mix_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
      prev_left  <= '0;
      prev_right <= '0;
    end else if (adv) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (s2_valid && lowpass_enable) begin
        prev_left  <= avg_l;
        prev_right <= avg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_psg <= head_word.psg.neg;
      s1_neg_l   <= head_word.fm_left.neg;
      s1_neg_r   <= head_word.fm_right.neg;
      s1_q_psg   <= div100(head_word.psg.mag);
      s1_q_l     <= div100(head_word.fm_left.mag);
      s1_q_r     <= div100(head_word.fm_right.mag);
      s2_mix_l   <= apply_sign(s1_neg_psg, s1_q_psg) + apply_sign(s1_neg_l, s1_q_l);
      s2_mix_r   <= apply_sign(s1_neg_psg, s1_q_psg) + apply_sign(s1_neg_r, s1_q_r);
      out_l      <= clip16(res_l);
      out_r      <= clip16(res_r);
    end
  end

`ifndef SYNTHESIS
  a_prev_left_hold: assert property (@(posedge clk) disable iff (rst)
      !$stable(prev_left) |-> ($past(lowpass_enable) || $past(rst)))
    else $error("left filter state changed with the low-pass off");
  a_prev_right_hold: assert property (@(posedge clk) disable iff (rst)
      !$stable(prev_right) |-> ($past(lowpass_enable) || $past(rst)))
    else $error("right filter state changed with the low-pass off");
  a_out_from_s2: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(s2_valid))
    else $error("output word appeared without a mixed word behind it");
`endif

endmodule

### sv/stereo_audio_mixer_lowpass_clip_top.sv
// ----------------------------------------------------------------------------
// stereo_audio_mixer_lowpass_clip_top: stereo mixer with low-pass and clip
// Scales a mono sample and a stereo sample by percentage gains, mixes them,
// optionally averages each channel with its previous value and saturates the
// result to 16 bits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake       Word
//  in_ch     sink       valid/ready     psg_sample, fm_left_sample,
//                                       fm_right_sample (signed 16 bits)
//  out_ch    source     valid/ready     left_out, right_out (signed 16 bits)
//  cfg       write      cfg_we          cfg_index selects the register,
//                                       cfg_data carries its value
//
//  One word is taken and one stereo word is given every clock cycle when
//  neither side stalls. A word passes five registers in turn: the gain
//  multipliers, the queue, the reciprocal multipliers that divide by one
//  hundred, the mixing adders, and the filter and saturation stage. The
//  low-pass state is the only feedback path and is updated in that last
//  stage, once per word while the low-pass is on.
//  Reset is synchronous and active high; it clears all valid flags, the
//  queue and the filter state, and sets both gains to 100 with the
//  low-pass off. A stall on the output holds the arithmetic pipeline, and
//  the four-word queue lets the input side keep accepting until it fills.
//
module stereo_audio_mixer_lowpass_clip_top import smix_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  smix_in_if.sink             in_ch,
  smix_out_if.source          out_ch
);

  // Configuration registers. Writes must arrive only while the mixer is idle;
  // the block does not enforce this or synchronise them with words in flight.
  logic [GainW-1:0] psg_gain;
  logic [GainW-1:0] fm_gain;
  logic             lowpass_enable;

  logic        queue_full;
  logic        push;
  front_word_t push_word;
  logic        pop;
  logic        head_valid;
  front_word_t head_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      psg_gain       <= GainReset;
      fm_gain        <= GainReset;
      lowpass_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PSG_GAIN: psg_gain       <= cfg_data[GainW-1:0];
        CFG_FM_GAIN:  fm_gain        <= cfg_data[GainW-1:0];
        CFG_LOWPASS:  lowpass_enable <= cfg_data[0];
        default: begin
          // Writes to an unknown index are dropped.
        end
      endcase
    end
  end

  // Front part: accepts the word and applies both gains as sign and
  // magnitude, so that the later divide truncates towards zero.
  smix_front u_front (
    .clk        (clk),
    .rst        (rst),
    .psg_gain   (psg_gain),
    .fm_gain    (fm_gain),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_word  (push_word)
  );

  // The queue decouples the two halves so that each stalls on its own.
  smix_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  // Back part: divide, mix, filter and saturate into the output register.
  smix_back u_back (
    .clk            (clk),
    .rst            (rst),
    .lowpass_enable (lowpass_enable),
    .head_valid     (head_valid),
    .head_word      (head_word),
    .pop            (pop),
    .out_ch         (out_ch)
  );

endmodule
